### rtl/core/ttn_pkg.sv
`default_nettype none

package ttn_pkg;

    // Field widths of the vertex and result beats.
    localparam int COORD_WIDTH = 32;
    localparam int DIR_WIDTH   = 16;

    // Mantissa width kept by the normaliser before the square root.
    localparam int MANT     = 30;
    // Edge and texture differences.
    localparam int EW       = COORD_WIDTH + 1;
    // Multiplier operand magnitude width, wide enough for edges and mantissas.
    localparam int MW       = (EW > MANT) ? EW : MANT;
    // Multiplier digits of eight bits each, most significant first.
    localparam int ND       = (MW + 7) / 8;
    localparam int BW       = ND * 8;
    localparam int PW       = 2 * MW;
    // Signed accumulator and stored vector widths.
    localparam int AW       = 2 * MW + 3;
    localparam int VW       = 2 * COORD_WIDTH + 3;
    // Fraction bits of a direction component.
    localparam int FB       = DIR_WIDTH - 2;
    // Square root operand width and the bound on the sum of squares.
    localparam int SW       = 2 * MANT + 4;
    localparam int QW       = 2 * MANT + 2;
    localparam int SQ_STEPS = SW / 2;
    // Root width and scaled dividend width.
    localparam int RW       = MANT + 2;
    localparam int NW       = MANT + FB + 1;
    localparam int CNT_W    = 6;
    localparam int PC_W     = 5;

    // Product program counter landmarks.
    localparam logic [PC_W-1:0] PC_TAN_END   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_NRM_START = PC_W'(8);
    localparam logic [PC_W-1:0] PC_NRM_END   = PC_W'(13);
    localparam logic [PC_W-1:0] PC_SQ_START  = PC_W'(14);
    localparam logic [PC_W-1:0] PC_SQ_END    = PC_W'(16);

    typedef struct packed {
        logic                          mesh_start;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [COORD_WIDTH-1:0] tex_u;
        logic signed [COORD_WIDTH-1:0] tex_v;
    } t_vtx;

    typedef struct packed {
        logic signed [DIR_WIDTH-1:0] tangent_x;
        logic signed [DIR_WIDTH-1:0] tangent_y;
        logic signed [DIR_WIDTH-1:0] tangent_z;
        logic signed [DIR_WIDTH-1:0] normal_x;
        logic signed [DIR_WIDTH-1:0] normal_y;
        logic signed [DIR_WIDTH-1:0] normal_z;
        logic                        degenerate;
    } t_res;

    typedef enum logic [3:0] {
        OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z,
        OP_DU1, OP_DV1, OP_DU2, OP_DV2, OP_M0, OP_M1, OP_M2
    } t_opnd;

    typedef struct packed {
        t_opnd      a;
        t_opnd      b;
        logic       sub;
        logic       last;
        logic [2:0] vidx;
    } t_term;

    typedef enum logic [3:0] {
        S_IDLE, S_MLOAD, S_MSTEP, S_MACC, S_VWR, S_TAN, S_SHIFT,
        S_SQLOAD, S_SQSTEP, S_DLOAD, S_DSTEP, S_DWR, S_NEXT, S_OUT
    } t_state;

    typedef struct packed {
        logic       load_c0;
        logic       load_c1;
        logic       load_tri;
        logic       acc_clr;
        logic       mul_load;
        t_opnd      a_sel;
        t_opnd      b_sel;
        logic       sub;
        logic       mul_step;
        logic       acc_add;
        logic       vec_wr;
        logic [2:0] vec_idx;
        logic       mag_load;
        logic       vsel;
        logic       mag_shift;
        logic       degen_set;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       div_load;
        logic [1:0] div_idx;
        logic       div_step;
        logic       res_wr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic mag_big;
        logic mag_zero;
    } t_sts;

    // Product program: determinant, tangent, face normal, sum of squares.
    function automatic t_term term_of(input logic [PC_W-1:0] pc);
        t_term t;
        case (pc)
            5'd0:    t = '{OP_DU1, OP_DV2, 1'b0, 1'b0, 3'd0};
            5'd1:    t = '{OP_DU2, OP_DV1, 1'b1, 1'b1, 3'd0};
            5'd2:    t = '{OP_DV2, OP_E1X, 1'b0, 1'b0, 3'd1};
            5'd3:    t = '{OP_DV1, OP_E2X, 1'b1, 1'b1, 3'd1};
            5'd4:    t = '{OP_DV2, OP_E1Y, 1'b0, 1'b0, 3'd2};
            5'd5:    t = '{OP_DV1, OP_E2Y, 1'b1, 1'b1, 3'd2};
            5'd6:    t = '{OP_DV2, OP_E1Z, 1'b0, 1'b0, 3'd3};
            5'd7:    t = '{OP_DV1, OP_E2Z, 1'b1, 1'b1, 3'd3};
            5'd8:    t = '{OP_E1Y, OP_E2Z, 1'b0, 1'b0, 3'd4};
            5'd9:    t = '{OP_E1Z, OP_E2Y, 1'b1, 1'b1, 3'd4};
            5'd10:   t = '{OP_E1Z, OP_E2X, 1'b0, 1'b0, 3'd5};
            5'd11:   t = '{OP_E1X, OP_E2Z, 1'b1, 1'b1, 3'd5};
            5'd12:   t = '{OP_E1X, OP_E2Y, 1'b0, 1'b0, 3'd6};
            5'd13:   t = '{OP_E1Y, OP_E2X, 1'b1, 1'b1, 3'd6};
            5'd14:   t = '{OP_M0, OP_M0, 1'b0, 1'b0, 3'd0};
            5'd15:   t = '{OP_M1, OP_M1, 1'b0, 1'b0, 3'd0};
            5'd16:   t = '{OP_M2, OP_M2, 1'b0, 1'b1, 3'd0};
            default: t = '{OP_M2, OP_M2, 1'b0, 1'b1, 3'd0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ttn_dp.sv
`default_nettype none

module ttn_dp
    import ttn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_vtx i_vtx,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_res      o_res
);

    logic signed [COORD_WIDTH-1:0] r_p0 [3];
    logic signed [COORD_WIDTH-1:0] r_p1 [3];
    logic signed [COORD_WIDTH-1:0] r_t0 [2];
    logic signed [COORD_WIDTH-1:0] r_t1 [2];
    logic signed [EW-1:0]          r_e1 [3];
    logic signed [EW-1:0]          r_e2 [3];
    logic signed [EW-1:0]          r_du1, r_dv1, r_du2, r_dv2;
    logic [MW-1:0]                 r_ma;
    logic [BW-1:0]                 r_mb;
    logic                          r_mneg;
    logic [PW-1:0]                 r_pm;
    logic signed [AW-1:0]          r_acc;
    logic signed [VW-1:0]          r_vec [7];
    logic [VW-1:0]                 r_mag [3];
    logic                          r_neg [3];
    logic [SW-1:0]                 r_sx, r_sr, r_sbit;
    logic [RW-1:0]                 r_rem;
    logic [FB:0]                   r_dlo, r_quo;
    logic signed [DIR_WIDTH-1:0]   r_tan [3];
    logic signed [DIR_WIDTH-1:0]   r_nrm [3];
    logic                          r_degen;
    t_res                          r_out;

    logic signed [MW:0]  w_ops [13];
    logic signed [MW:0]  w_a, w_b;
    logic [MW-1:0]       w_amag, w_bmag;
    logic [MW+7:0]       w_pp;
    logic [VW-1:0]       w_or;
    logic [SW-1:0]       w_trial;
    logic [RW-1:0]       w_root, w_rt;
    logic [NW-1:0]       w_num;
    logic [FB:0]         w_c;
    logic [DIR_WIDTH-1:0] w_cs;
    logic signed [DIR_WIDTH-1:0] w_dir;
    logic                w_dneg;

    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ops[0]  = (MW+1)'(r_e1[0]);
        w_ops[1]  = (MW+1)'(r_e1[1]);
        w_ops[2]  = (MW+1)'(r_e1[2]);
        w_ops[3]  = (MW+1)'(r_e2[0]);
        w_ops[4]  = (MW+1)'(r_e2[1]);
        w_ops[5]  = (MW+1)'(r_e2[2]);
        w_ops[6]  = (MW+1)'(r_du1);
        w_ops[7]  = (MW+1)'(r_dv1);
        w_ops[8]  = (MW+1)'(r_du2);
        w_ops[9]  = (MW+1)'(r_dv2);
        w_ops[10] = signed'((MW+1)'(r_mag[0][MANT-1:0]));
        w_ops[11] = signed'((MW+1)'(r_mag[1][MANT-1:0]));
        w_ops[12] = signed'((MW+1)'(r_mag[2][MANT-1:0]));
        w_a = w_ops[i_cmd.a_sel];
        w_b = w_ops[i_cmd.b_sel];
    end

    assign w_amag = w_a[MW] ? MW'(-w_a) : MW'(w_a);
    assign w_bmag = w_b[MW] ? MW'(-w_b) : MW'(w_b);
    assign w_pp   = (MW+8)'(r_ma) * (MW+8)'(r_mb[BW-1 -: 8]);

    // Normaliser, square root and divider combinational terms.
    assign w_or    = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_trial = r_sr + r_sbit;
    assign w_root  = r_sr[RW-1:0];
    assign w_num   = (NW'(r_mag[i_cmd.div_idx][MANT-1:0]) << FB) + NW'(w_root >> 1);
    assign w_rt    = {r_rem[RW-2:0], r_dlo[FB]};
    assign w_c     = (r_quo > ONE) ? ONE : r_quo;
    assign w_cs    = DIR_WIDTH'(w_c);
    assign w_dneg  = r_neg[i_cmd.div_idx] ^ (!i_cmd.vsel & r_vec[0][VW-1]);
    assign w_dir   = w_dneg ? -signed'(w_cs) : signed'(w_cs);

    // Held corners and the edge and texture differences.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_c0) begin
            r_p0[0] <= i_vtx.pos_x;
            r_p0[1] <= i_vtx.pos_y;
            r_p0[2] <= i_vtx.pos_z;
            r_t0[0] <= i_vtx.tex_u;
            r_t0[1] <= i_vtx.tex_v;
        end
        if (i_cmd.load_c1) begin
            r_p1[0] <= i_vtx.pos_x;
            r_p1[1] <= i_vtx.pos_y;
            r_p1[2] <= i_vtx.pos_z;
            r_t1[0] <= i_vtx.tex_u;
            r_t1[1] <= i_vtx.tex_v;
        end
        if (i_cmd.load_tri) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EW'(r_p1[i]) - EW'(r_p0[i]);
            end
            r_e2[0] <= EW'(i_vtx.pos_x) - EW'(r_p0[0]);
            r_e2[1] <= EW'(i_vtx.pos_y) - EW'(r_p0[1]);
            r_e2[2] <= EW'(i_vtx.pos_z) - EW'(r_p0[2]);
            r_du1   <= EW'(r_t1[0]) - EW'(r_t0[0]);
            r_dv1   <= EW'(r_t1[1]) - EW'(r_t0[1]);
            r_du2   <= EW'(i_vtx.tex_u) - EW'(r_t0[0]);
            r_dv2   <= EW'(i_vtx.tex_v) - EW'(r_t0[1]);
        end
    end

    // Digit-serial multiplier and signed accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_ma   <= w_amag;
            r_mb   <= BW'(w_bmag);
            r_mneg <= w_a[MW] ^ w_b[MW] ^ i_cmd.sub;
            r_pm   <= '0;
        end else if (i_cmd.mul_step) begin
            r_pm <= (r_pm << 8) + PW'(w_pp);
            r_mb <= r_mb << 8;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_mneg ? r_acc - signed'(AW'(r_pm)) : r_acc + signed'(AW'(r_pm));
        end
        if (i_cmd.vec_wr) begin
            r_vec[i_cmd.vec_idx] <= VW'(r_acc);
        end
    end

    // Magnitudes, shifted down together until they fit the mantissa.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_load) begin
            for (int i = 0; i < 3; i++) begin
                if (i_cmd.vsel) begin
                    r_neg[i] <= r_vec[4+i][VW-1];
                    r_mag[i] <= r_vec[4+i][VW-1] ? VW'(-r_vec[4+i]) : VW'(r_vec[4+i]);
                end else begin
                    r_neg[i] <= r_vec[1+i][VW-1];
                    r_mag[i] <= r_vec[1+i][VW-1] ? VW'(-r_vec[1+i]) : VW'(r_vec[1+i]);
                end
            end
        end else if (i_cmd.mag_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= r_mag[i] >> 1;
            end
        end
    end

    // Integer square root, two bits of operand per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_sx   <= SW'(r_acc[QW-1:0]);
            r_sr   <= '0;
            r_sbit <= SW'(1) << (SW - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_sx >= w_trial) begin
                r_sx <= r_sx - w_trial;
                r_sr <= (r_sr >> 1) + r_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // Restoring divider, one quotient bit per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= RW'(w_num >> (FB + 1));
            r_dlo <= w_num[FB:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (w_rt >= w_root) begin
                r_rem <= w_rt - w_root;
                r_quo <= {r_quo[FB-1:0], 1'b1};
            end else begin
                r_rem <= w_rt;
                r_quo <= {r_quo[FB-1:0], 1'b0};
            end
            r_dlo <= r_dlo << 1;
        end
    end

    // Result assembly and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tri) begin
            for (int i = 0; i < 3; i++) begin
                r_tan[i] <= '0;
                r_nrm[i] <= '0;
            end
            r_degen <= 1'b0;
        end else begin
            if (i_cmd.res_wr) begin
                if (i_cmd.vsel) begin
                    r_nrm[i_cmd.div_idx] <= w_dir;
                end else begin
                    r_tan[i_cmd.div_idx] <= w_dir;
                end
            end
            if (i_cmd.degen_set) begin
                r_degen <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out.tangent_x  <= r_tan[0];
            r_out.tangent_y  <= r_tan[1];
            r_out.tangent_z  <= r_tan[2];
            r_out.normal_x   <= r_nrm[0];
            r_out.normal_y   <= r_nrm[1];
            r_out.normal_z   <= r_nrm[2];
            r_out.degenerate <= r_degen;
        end
    end

    assign o_sts.det_zero = (r_vec[0] == '0);
    assign o_sts.mag_big  = |w_or[VW-1:MANT];
    assign o_sts.mag_zero = (w_or == '0);
    assign o_res          = r_out;

    // A division only starts once the square root has found a nonzero root.
    a_div_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_load |-> (w_root != '0))
        else $error("division started with zero root");

    // A finished quotient never exceeds one in direction format.
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_wr |-> (r_quo <= ONE))
        else $error("direction quotient above one");

endmodule

`default_nettype wire

### rtl/core/ttn_ctrl.sv
`default_nettype none

module ttn_ctrl
    import ttn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_mesh_start,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state           r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_di, n_di;
    logic             r_vsel, n_vsel;
    logic             r_mode;
    logic             r_ovalid, n_ovalid;
    t_cmd             cmd;
    t_term            w_term;
    logic             w_acc;
    logic [1:0]       w_phase;

    assign w_term  = term_of(r_pc);
    assign w_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_phase = i_mesh_start ? 2'd0 : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 2'd0;
            r_pc     <= '0;
            r_cnt    <= '0;
            r_di     <= '0;
            r_vsel   <= 1'b0;
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pc     <= n_pc;
            r_cnt    <= n_cnt;
            r_di     <= n_di;
            r_vsel   <= n_vsel;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    // Sequencer: products, then normalisation of the tangent and, with the face normal mode on, the face normal.
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_di     = r_di;
        n_vsel   = r_vsel;
        n_ovalid = r_ovalid && !i_out_ready;
        cmd         = '0;
        cmd.a_sel   = w_term.a;
        cmd.b_sel   = w_term.b;
        cmd.sub     = w_term.sub;
        cmd.vec_idx = w_term.vidx;
        cmd.vsel    = r_vsel;
        cmd.div_idx = r_di;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_phase == 2'd0) begin
                        cmd.load_c0 = 1'b1;
                        n_phase     = 2'd1;
                    end else if (w_phase == 2'd1) begin
                        cmd.load_c1 = 1'b1;
                        n_phase     = 2'd2;
                    end else begin
                        cmd.load_tri = 1'b1;
                        cmd.acc_clr  = 1'b1;
                        n_phase      = 2'd0;
                        n_pc         = '0;
                        n_state      = S_MLOAD;
                    end
                end
            end
            S_MLOAD: begin
                cmd.mul_load = 1'b1;
                n_cnt        = '0;
                n_state      = S_MSTEP;
            end
            S_MSTEP: begin
                cmd.mul_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ND - 1)) begin
                    n_state = S_MACC;
                end
            end
            S_MACC: begin
                cmd.acc_add = 1'b1;
                if (!w_term.last) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_MLOAD;
                end else if (r_pc == PC_SQ_END) begin
                    n_state = S_SQLOAD;
                end else begin
                    n_state = S_VWR;
                end
            end
            S_VWR: begin
                cmd.vec_wr  = 1'b1;
                cmd.acc_clr = 1'b1;
                if ((r_pc == PC_TAN_END && !r_mode) || r_pc == PC_NRM_END) begin
                    n_state = S_TAN;
                end else begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_MLOAD;
                end
            end
            S_TAN: begin
                n_vsel = 1'b0;
                if (i_sts.det_zero) begin
                    cmd.degen_set = 1'b1;
                    n_state       = S_NEXT;
                end else begin
                    cmd.mag_load = 1'b1;
                    cmd.vsel     = 1'b0;
                    n_state      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.mag_big) begin
                    cmd.mag_shift = 1'b1;
                end else if (i_sts.mag_zero) begin
                    cmd.degen_set = 1'b1;
                    n_state       = S_NEXT;
                end else begin
                    cmd.acc_clr = 1'b1;
                    n_pc        = PC_SQ_START;
                    n_state     = S_MLOAD;
                end
            end
            S_SQLOAD: begin
                cmd.sqrt_load = 1'b1;
                n_cnt         = '0;
                n_di          = '0;
                n_state       = S_SQSTEP;
            end
            S_SQSTEP: begin
                cmd.sqrt_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                cmd.div_load = 1'b1;
                n_cnt        = '0;
                n_state      = S_DSTEP;
            end
            S_DSTEP: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FB)) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                cmd.res_wr = 1'b1;
                if (r_di == 2'd2) begin
                    n_state = S_NEXT;
                end else begin
                    n_di    = r_di + 1'b1;
                    n_state = S_DLOAD;
                end
            end
            S_NEXT: begin
                if (!r_vsel && r_mode) begin
                    n_vsel       = 1'b1;
                    cmd.mag_load = 1'b1;
                    cmd.vsel     = 1'b1;
                    n_state      = S_SHIFT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

    // A result beat is only loaded when the output register is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_ovalid || i_out_ready))
        else $error("output register overwritten");

    // A completing corner starts the product program from its beginning.
    a_tri_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && cmd.load_tri) |=> (r_state == S_MLOAD && r_pc == '0 && r_phase == 2'd0))
        else $error("triangle did not start the product program");

    // The square root always hands over to the divider after its last step.
    a_sqrt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQSTEP && r_cnt == CNT_W'(SQ_STEPS - 1)) |=> (r_state == S_DLOAD))
        else $error("square root did not hand over to the divider");

endmodule

`default_nettype wire

### rtl/core/triangle_tangent_normal.sv
`default_nettype none

// Per-triangle tangent and face normal unit. Vertices arrive one beat at a time as an
// unindexed triangle list; the first two corners of a triangle are taken at one beat per
// cycle, and the third corner starts the computation, during which the input is not ready.
// The computation runs the determinant and tangent products on the shared 33x8 multiplier
// (ND = 5 eight-bit digits), the face normal products too with the face normal mode on,
// and per normalised vector a magnitude load, the alignment shifts, the sum of squares,
// the two-bit-per-step square root and a one-bit-per-step division per component. The
// finished result sits in an output register, so the next vertices are taken while it
// waits to be read. A mesh start mark drops any partial triangle; the user must write the
// face normal mode only while the unit is idle, as the unit has no check for it.
module triangle_tangent_normal
    import ttn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_vtx i_in_vtx,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_res      o_out_res,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    ttn_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_mesh_start (i_in_vtx.mesh_start),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    ttn_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_in_vtx),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_out_res)
    );

endmodule

`default_nettype wire
